// ===== rtl/ttac_pkg.sv =====
// ----------------------------------------------------------------------------
// ttac_pkg
// Shared types, codes and reset constants for the timed-travel actuator
// controller.
// ----------------------------------------------------------------------------
package ttac_pkg;

    localparam int MOTORS_DEF  = 6;
    localparam int TRAVEL_REGS = 6;
    localparam int POS_W       = 16;
    localparam int MASK_W      = 6;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic       OP_CMD  = 1'b0;
    localparam logic       OP_TICK = 1'b1;

    localparam logic [1:0] CMD_UP   = 2'd0;
    localparam logic [1:0] CMD_DOWN = 2'd1;
    localparam logic [1:0] CMD_STOP = 2'd2;

    localparam logic [2:0] REG_WIRED   = 3'd0;
    localparam logic [2:0] REG_TRAVEL0 = 3'd1;
    localparam logic [2:0] REG_TRAVEL5 = 3'd6;

    typedef enum logic [1:0] {
        MS_TOP     = 2'd0,
        MS_BOTTOM  = 2'd1,
        MS_TRANSIT = 2'd2
    } motor_state_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_TICK,
        ST_DONE
    } ctrl_state_t;

    // One memory entry: travel state and soft position of one motor.
    typedef struct packed {
        logic [1:0]       mstate;
        logic [POS_W-1:0] pos;
    } entry_t;

    localparam logic [1:0] WIRED_RESET = 2'd1;

    function automatic logic [POS_W-1:0] travel_reset(input logic [2:0] idx);
        logic [POS_W-1:0] val;
        case (idx)
            3'd0:    val = 16'd10000;
            3'd2:    val = 16'd10000;
            default: val = 16'd5000;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/timed_travel_actuator_controller_unit.sv =====
// ----------------------------------------------------------------------------
// timed_travel_actuator_controller_unit
// Six-channel stepper actuator controller with time-based soft travel limits.
// ----------------------------------------------------------------------------
// Each request is either a command (up, down or stop) for one motor or a
// one-millisecond tick. Per-motor position and travel state live in a small
// synchronous memory with a registered read. A command reads its motor's entry,
// modifies it and writes it back, and then loads its result. A tick sweeps the
// memory one motor per cycle with the read of the next entry overlapped with
// the write of the current one. One request is worked on at a time; the result
// register lets the next request enter while a finished result waits to be
// taken. Configuration registers sit at byte addresses 4*i on the APB-style port.
module timed_travel_actuator_controller_unit #(
    parameter int MOTORS = ttac_pkg::MOTORS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [2:0]                    motor,
    input  logic [1:0]                    command,
    input  logic                          emergency_stop,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [ttac_pkg::MASK_W-1:0]   stepping_mask,
    output logic [ttac_pkg::MASK_W-1:0]   driver_disabled_mask,
    output logic [ttac_pkg::MASK_W-1:0]   direction_up_mask,
    output logic [1:0]                    motor_state,
    output logic [ttac_pkg::POS_W-1:0]    motor_position,
    output logic                          command_ignored,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ttac_pkg::ADDR_W-1:0]   paddr,
    input  logic [ttac_pkg::DATA_W-1:0]   pwdata,
    output logic [ttac_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int AW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam logic [2:0]    MOTORS_M  = 3'(MOTORS);
    localparam logic [AW-1:0] LAST_IDX  = AW'(MOTORS - 1);
    localparam logic [AW:0]   MOTORS_AW = (AW + 1)'(MOTORS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ttac_pkg::MASK_W-1:0] wired_reg;
    logic [ttac_pkg::POS_W-1:0]  travel_reg [ttac_pkg::TRAVEL_REGS];
    logic [2:0]                  cfg_idx;
    logic [2:0]                  cfg_tidx;
    logic                        cfg_wr;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[4:2];
    assign cfg_tidx = cfg_idx - ttac_pkg::REG_TRAVEL0;
    assign cfg_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wired_reg <= ttac_pkg::MASK_W'(ttac_pkg::WIRED_RESET);
            for (int i = 0; i < ttac_pkg::TRAVEL_REGS; i++)
            begin
                travel_reg[i] <= ttac_pkg::travel_reset(3'(i));
            end
        end
        else if (cfg_wr)
        begin
            if (cfg_idx == ttac_pkg::REG_WIRED)
            begin
                wired_reg <= pwdata[ttac_pkg::MASK_W-1:0];
            end
            else if (cfg_idx <= ttac_pkg::REG_TRAVEL5)
            begin
                travel_reg[cfg_tidx] <= pwdata[ttac_pkg::POS_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_idx == ttac_pkg::REG_WIRED)
        begin
            prdata = ttac_pkg::DATA_W'(wired_reg);
        end
        else if (cfg_idx <= ttac_pkg::REG_TRAVEL5)
        begin
            prdata = ttac_pkg::DATA_W'(travel_reg[cfg_tidx]);
        end
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    ttac_pkg::ctrl_state_t state_reg, state_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic                  in_accept;
    logic                  out_load;
    logic                  out_valid_reg;

    assign in_accept = in_valid & ~in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ttac_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (op == ttac_pkg::OP_TICK) ? ttac_pkg::ST_TICK
                                                           : ttac_pkg::ST_CMD;
                end
            end
            ttac_pkg::ST_CMD:  state_next = ttac_pkg::ST_DONE;
            ttac_pkg::ST_TICK:
            begin
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ttac_pkg::ST_DONE;
                end
            end
            ttac_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ttac_pkg::ST_IDLE;
                end
            end
            default: state_next = ttac_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != ttac_pkg::ST_IDLE);
        out_load = (state_reg == ttac_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
        cnt_next = cnt_reg;
        case (state_reg)
            ttac_pkg::ST_IDLE: cnt_next = '0;
            ttac_pkg::ST_TICK: cnt_next = cnt_reg + 1'b1;
            default:           cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttac_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_load | (out_valid_reg & out_stall);
        end
    end

    // ------------------------------------------------------------------
    // Captured request
    // ------------------------------------------------------------------
    logic          op_reg;
    logic [AW-1:0] m_reg;
    logic          m_ok_reg;
    logic [1:0]    cmd_reg;
    logic          estop_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= op;
            m_reg     <= motor[AW-1:0];
            m_ok_reg  <= (motor < MOTORS_M);
            cmd_reg   <= command;
            estop_reg <= emergency_stop;
        end
    end

    // ------------------------------------------------------------------
    // State memory: position and travel state per motor
    // ------------------------------------------------------------------
    ttac_pkg::entry_t mem [MOTORS];
    logic [MOTORS-1:0] valid_reg;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     tick_next_idx;
    ttac_pkg::entry_t  rd_data_reg;
    logic              rd_valid_reg;
    ttac_pkg::entry_t  rd_entry;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    ttac_pkg::entry_t  wr_data;

    assign tick_next_idx = cnt_reg + 1'b1;

    // Ticks read entry 0 at acceptance and then the next entry while the
    // current one is written back, so reads and writes never hit the same entry.
    always_comb
    begin
        rd_addr = '0;
        case (state_reg)
            ttac_pkg::ST_IDLE: rd_addr = (op == ttac_pkg::OP_TICK) ? '0 : motor[AW-1:0];
            ttac_pkg::ST_TICK: rd_addr = tick_next_idx;
            default:           rd_addr = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if ({1'b0, rd_addr} < MOTORS_AW)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= ({1'b0, rd_addr} < MOTORS_AW) ? valid_reg[rd_addr] : 1'b0;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // An entry never written reads as position 0 at the top.
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

    // ------------------------------------------------------------------
    // Read-modify-write datapath
    // ------------------------------------------------------------------
    logic [MOTORS-1:0]          running_reg, running_next;
    logic [MOTORS-1:0]          dir_up_reg, dir_up_next;
    logic [1:0]                 res_state_reg, res_state_next;
    logic [ttac_pkg::POS_W-1:0] res_pos_reg, res_pos_next;
    logic                       res_ign_reg, res_ign_next;
    logic [AW-1:0]              idx;
    logic [ttac_pkg::POS_W:0]   pos_inc;
    logic [ttac_pkg::POS_W-1:0] trav;
    logic                       run_new;
    logic                       reject;

    assign idx     = (state_reg == ttac_pkg::ST_TICK) ? cnt_reg : m_reg;
    assign trav    = travel_reg[idx];
    assign pos_inc = {1'b0, rd_entry.pos} + 1'b1;

    always_comb
    begin
        running_next   = running_reg;
        dir_up_next    = dir_up_reg;
        res_state_next = res_state_reg;
        res_pos_next   = res_pos_reg;
        res_ign_next   = res_ign_reg;
        wr_en          = 1'b0;
        wr_addr        = idx;
        wr_data        = rd_entry;
        run_new        = running_reg[idx];
        reject         = 1'b1;
        case (state_reg)
            ttac_pkg::ST_IDLE:
            begin
                res_state_next = '0;
                res_pos_next   = '0;
                res_ign_next   = 1'b0;
            end
            ttac_pkg::ST_CMD:
            begin
                if (m_ok_reg)
                begin
                    case (cmd_reg)
                        ttac_pkg::CMD_UP:
                            reject = estop_reg || (rd_entry.mstate == ttac_pkg::MS_TOP);
                        ttac_pkg::CMD_DOWN:
                            reject = estop_reg || (rd_entry.mstate == ttac_pkg::MS_BOTTOM);
                        ttac_pkg::CMD_STOP:
                            reject = 1'b0;
                        default:
                            reject = 1'b1;
                    endcase
                    if (!wired_reg[idx])
                    begin
                        reject = 1'b1;
                    end
                    if (!reject)
                    begin
                        wr_en = 1'b1;
                        if (cmd_reg == ttac_pkg::CMD_STOP)
                        begin
                            running_next[idx] = 1'b0;
                        end
                        else
                        begin
                            running_next[idx] = 1'b1;
                            dir_up_next[idx]  = (cmd_reg == ttac_pkg::CMD_UP);
                            wr_data.mstate    = ttac_pkg::MS_TRANSIT;
                        end
                    end
                    res_state_next = wr_data.mstate;
                    res_pos_next   = wr_data.pos;
                end
                res_ign_next = reject;
            end
            ttac_pkg::ST_TICK:
            begin
                if (running_reg[idx])
                begin
                    wr_en = 1'b1;
                    if (dir_up_reg[idx])
                    begin
                        if (rd_entry.pos <= ttac_pkg::POS_W'(1))
                        begin
                            wr_data.pos    = '0;
                            wr_data.mstate = ttac_pkg::MS_TOP;
                            run_new        = 1'b0;
                        end
                        else
                        begin
                            wr_data.pos = rd_entry.pos - 1'b1;
                        end
                    end
                    else if (pos_inc >= {1'b0, trav})
                    begin
                        wr_data.pos    = trav;
                        wr_data.mstate = ttac_pkg::MS_BOTTOM;
                        run_new        = 1'b0;
                    end
                    else
                    begin
                        wr_data.pos = pos_inc[ttac_pkg::POS_W-1:0];
                    end
                end
                // The emergency stop on a tick halts wired motors only.
                if (estop_reg && wired_reg[idx])
                begin
                    run_new = 1'b0;
                end
                running_next[idx] = run_new;
                if (m_ok_reg && (m_reg == idx))
                begin
                    res_state_next = wr_data.mstate;
                    res_pos_next   = wr_data.pos;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            dir_up_reg  <= '0;
        end
        else
        begin
            running_reg <= running_next;
            dir_up_reg  <= dir_up_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_state_reg <= res_state_next;
        res_pos_reg   <= res_pos_next;
        res_ign_reg   <= res_ign_next;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [ttac_pkg::MASK_W-1:0] step_out_reg;
    logic [ttac_pkg::MASK_W-1:0] up_out_reg;
    logic [1:0]                  mstate_out_reg;
    logic [ttac_pkg::POS_W-1:0]  pos_out_reg;
    logic                        ign_out_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            step_out_reg   <= ttac_pkg::MASK_W'(running_reg);
            up_out_reg     <= ttac_pkg::MASK_W'(dir_up_reg);
            mstate_out_reg <= res_state_reg;
            pos_out_reg    <= res_pos_reg;
            ign_out_reg    <= res_ign_reg;
        end
    end

    assign out_valid            = out_valid_reg;
    assign stepping_mask        = step_out_reg;
    assign driver_disabled_mask = ~step_out_reg;
    assign direction_up_mask    = up_out_reg;
    assign motor_state          = mstate_out_reg;
    assign motor_position       = pos_out_reg;
    assign command_ignored      = ign_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ttac_pkg::ST_CMD) || (state_reg == ttac_pkg::ST_TICK))
        else $error("state memory written outside a command or tick");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttac_pkg::ST_TICK) |-> ({1'b0, cnt_reg} < MOTORS_AW))
        else $error("tick sweep index past the last motor");

    a_tick_not_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ttac_pkg::ST_DONE && op_reg == ttac_pkg::OP_TICK) |-> !res_ign_reg)
        else $error("tick result flagged as ignored command");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ttac_pkg::ST_DONE))
        else $error("result presented without a finished request");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(pos_out_reg) && $stable(step_out_reg))
        else $error("waiting result changed under stall");

endmodule
